// ===== rtl/core/cspu_pkg.sv =====
// Shared types and constants for the CPU state per-mille unit.
package cspu_pkg;

	localparam int CNT_W     = 32;   // tick counter width
	localparam int NUM_LANES = 4;    // user, nice, system, idle
	localparam int LANE_W    = 2;
	localparam int PERMILLE  = 1000;
	localparam int SHARE_W   = 10;
	localparam int TOTAL_W   = 34;   // sum of four differences
	localparam int HALF_W    = TOTAL_W - 1;
	localparam int PROD_W    = CNT_W + SHARE_W;
	localparam int NUM_W     = 44;   // diff*1000 + half, with headroom
	localparam int DIV_STEPS = SHARE_W;
	localparam int DCNT_W    = 4;
	localparam int PC_W      = 4;
	localparam int IN_W      = 128;
	localparam int OUT_W     = 88;
	localparam int OUT_PAD_W = OUT_W - NUM_LANES * SHARE_W - SHARE_W - TOTAL_W;

	// datapath operations, one per microcode step
	typedef enum logic [3:0] {
		OP_LOAD,
		OP_SUM_A,
		OP_SUM_B,
		OP_SUM_C,
		OP_FIX,
		OP_MUL,
		OP_ADDH,
		OP_DINIT,
		OP_DSTEP,
		OP_STORE,
		OP_OUT
	} op_t;

	// branch conditions
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_IN,
		C_OUT_BUSY,
		C_DIV_MORE,
		C_LANE_MORE
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           hold;    // stay on this step while true
		cond_t           jump;    // else branch to target while true
		logic [PC_W-1:0] target;
	} ucode_t;

	typedef struct packed {
		op_t  op;
		logic en;
	} ctrl_t;

	typedef struct packed {
		logic div_more;
		logic lane_more;
		logic out_busy;
	} stat_t;

endpackage

// ===== rtl/core/cspu_seq.sv =====
// Microcode sequencer: program ROM, step counter and branch logic.
module cspu_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  cspu_pkg::stat_t stat,
	output cspu_pkg::ctrl_t ctrl,
	output logic            in_ready
);

	localparam logic [cspu_pkg::PC_W-1:0] PC_IDLE  = cspu_pkg::PC_W'(0);
	localparam logic [cspu_pkg::PC_W-1:0] PC_MUL   = cspu_pkg::PC_W'(5);
	localparam logic [cspu_pkg::PC_W-1:0] PC_DSTEP = cspu_pkg::PC_W'(8);

	function automatic cspu_pkg::ucode_t rom(input logic [cspu_pkg::PC_W-1:0] addr);
		cspu_pkg::ucode_t w;
		w = '{op: cspu_pkg::OP_DINIT, hold: cspu_pkg::C_NEVER,
			jump: cspu_pkg::C_ALWAYS, target: PC_IDLE};
		case (addr)
			4'd0: w = '{op: cspu_pkg::OP_LOAD, hold: cspu_pkg::C_NO_IN,
				jump: cspu_pkg::C_NEVER, target: PC_IDLE};
			4'd1: w = '{op: cspu_pkg::OP_SUM_A, hold: cspu_pkg::C_NEVER,
				jump: cspu_pkg::C_NEVER, target: PC_IDLE};
			4'd2: w = '{op: cspu_pkg::OP_SUM_B, hold: cspu_pkg::C_NEVER,
				jump: cspu_pkg::C_NEVER, target: PC_IDLE};
			4'd3: w = '{op: cspu_pkg::OP_SUM_C, hold: cspu_pkg::C_NEVER,
				jump: cspu_pkg::C_NEVER, target: PC_IDLE};
			4'd4: w = '{op: cspu_pkg::OP_FIX, hold: cspu_pkg::C_NEVER,
				jump: cspu_pkg::C_NEVER, target: PC_IDLE};
			4'd5: w = '{op: cspu_pkg::OP_MUL, hold: cspu_pkg::C_NEVER,
				jump: cspu_pkg::C_NEVER, target: PC_IDLE};
			4'd6: w = '{op: cspu_pkg::OP_ADDH, hold: cspu_pkg::C_NEVER,
				jump: cspu_pkg::C_NEVER, target: PC_IDLE};
			4'd7: w = '{op: cspu_pkg::OP_DINIT, hold: cspu_pkg::C_NEVER,
				jump: cspu_pkg::C_NEVER, target: PC_IDLE};
			4'd8: w = '{op: cspu_pkg::OP_DSTEP, hold: cspu_pkg::C_NEVER,
				jump: cspu_pkg::C_DIV_MORE, target: PC_DSTEP};
			4'd9: w = '{op: cspu_pkg::OP_STORE, hold: cspu_pkg::C_NEVER,
				jump: cspu_pkg::C_LANE_MORE, target: PC_MUL};
			4'd10: w = '{op: cspu_pkg::OP_OUT, hold: cspu_pkg::C_OUT_BUSY,
				jump: cspu_pkg::C_ALWAYS, target: PC_IDLE};
			default: w = '{op: cspu_pkg::OP_DINIT, hold: cspu_pkg::C_NEVER,
				jump: cspu_pkg::C_ALWAYS, target: PC_IDLE};
		endcase
		return w;
	endfunction

	logic [cspu_pkg::PC_W-1:0] pc_q;
	cspu_pkg::ucode_t          uw;
	logic                      hold_c;
	logic                      jump_c;

	function automatic logic eval(input cspu_pkg::cond_t c, input logic vld,
			input cspu_pkg::stat_t st);
		logic r;
		r = 1'b0;
		case (c)
			cspu_pkg::C_NEVER:     r = 1'b0;
			cspu_pkg::C_ALWAYS:    r = 1'b1;
			cspu_pkg::C_NO_IN:     r = !vld;
			cspu_pkg::C_OUT_BUSY:  r = st.out_busy;
			cspu_pkg::C_DIV_MORE:  r = st.div_more;
			cspu_pkg::C_LANE_MORE: r = st.lane_more;
			default:               r = 1'b0;
		endcase
		return r;
	endfunction

	always_comb begin
		uw       = rom(pc_q);
		hold_c   = eval(uw.hold, in_valid, stat);
		jump_c   = eval(uw.jump, in_valid, stat);
		ctrl.op  = uw.op;
		ctrl.en  = !hold_c;
		in_ready = (pc_q == PC_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else if (!hold_c) begin
			pc_q <= jump_c ? uw.target : pc_q + cspu_pkg::PC_W'(1);
		end
	end

endmodule

// ===== rtl/core/cspu_dp.sv =====
// Datapath: sample store, tick sum, scaled restoring divider, result register.
module cspu_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cspu_pkg::ctrl_t             ctrl,
	input  logic [cspu_pkg::IN_W-1:0]   in_data,
	input  logic                        out_ready,
	output cspu_pkg::stat_t             stat,
	output logic                        out_valid,
	output logic [cspu_pkg::OUT_W-1:0]  out_data
);

	logic [cspu_pkg::CNT_W-1:0]   prev_q  [cspu_pkg::NUM_LANES];
	logic [cspu_pkg::CNT_W-1:0]   diff_q  [cspu_pkg::NUM_LANES];
	logic [cspu_pkg::SHARE_W-1:0] share_q [cspu_pkg::NUM_LANES];
	logic [cspu_pkg::TOTAL_W-1:0] acc_q;
	logic [cspu_pkg::HALF_W-1:0]  half_q;
	logic [cspu_pkg::NUM_W-1:0]   num_q;
	logic [cspu_pkg::TOTAL_W-1:0] rem_q;
	logic [cspu_pkg::SHARE_W-1:0] shf_q;
	logic [cspu_pkg::SHARE_W-1:0] quo_q;
	logic [cspu_pkg::SHARE_W-1:0] psum_q;
	logic [cspu_pkg::DCNT_W-1:0]  dcnt_q;
	logic [cspu_pkg::LANE_W-1:0]  lane_q;
	logic                         out_valid_q;
	logic [cspu_pkg::OUT_W-1:0]   out_data_q;

	logic [cspu_pkg::PROD_W-1:0]    prod;
	logic [cspu_pkg::TOTAL_W+1:0]   trial;
	logic                           ge;

	// one multiply per lane, one trial subtract per quotient bit
	assign prod  = cspu_pkg::PROD_W'(diff_q[lane_q]) * cspu_pkg::PROD_W'(cspu_pkg::PERMILLE);
	assign trial = {1'b0, rem_q, shf_q[cspu_pkg::SHARE_W-1]} - {2'b00, acc_q};
	assign ge    = !trial[cspu_pkg::TOTAL_W+1];

	assign stat.div_more  = (dcnt_q != cspu_pkg::DCNT_W'(cspu_pkg::DIV_STEPS - 1));
	assign stat.lane_more = (lane_q != cspu_pkg::LANE_W'(cspu_pkg::NUM_LANES - 1));
	assign stat.out_busy  = out_valid_q && !out_ready;
	assign out_valid      = out_valid_q;
	assign out_data       = out_data_q;

	// previous sample is architectural state and resets to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cspu_pkg::NUM_LANES; i++)
				prev_q[i] <= '0;
		end else if (ctrl.en && ctrl.op == cspu_pkg::OP_LOAD) begin
			for (int i = 0; i < cspu_pkg::NUM_LANES; i++)
				prev_q[i] <= in_data[i*cspu_pkg::CNT_W +: cspu_pkg::CNT_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q      <= '0;
			lane_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result takes precedence over the one leaving
			if (ctrl.en && ctrl.op == cspu_pkg::OP_OUT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (ctrl.en) begin
				case (ctrl.op)
					cspu_pkg::OP_FIX:   lane_q <= '0;
					cspu_pkg::OP_DINIT: dcnt_q <= '0;
					cspu_pkg::OP_DSTEP: dcnt_q <= dcnt_q + cspu_pkg::DCNT_W'(1);
					cspu_pkg::OP_STORE: lane_q <= lane_q + cspu_pkg::LANE_W'(1);
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			case (ctrl.op)
				cspu_pkg::OP_LOAD: begin
					for (int i = 0; i < cspu_pkg::NUM_LANES; i++)
						diff_q[i] <= in_data[i*cspu_pkg::CNT_W +: cspu_pkg::CNT_W] - prev_q[i];
				end
				cspu_pkg::OP_SUM_A: acc_q <= cspu_pkg::TOTAL_W'(diff_q[0])
					+ cspu_pkg::TOTAL_W'(diff_q[1]);
				cspu_pkg::OP_SUM_B: acc_q <= acc_q + cspu_pkg::TOTAL_W'(diff_q[2]);
				cspu_pkg::OP_SUM_C: acc_q <= acc_q + cspu_pkg::TOTAL_W'(diff_q[3]);
				cspu_pkg::OP_FIX: begin
					// no ticks elapsed: divide by one
					if (acc_q == '0)
						acc_q <= cspu_pkg::TOTAL_W'(1);
					half_q <= acc_q[cspu_pkg::TOTAL_W-1:1];
					psum_q <= '0;
				end
				cspu_pkg::OP_MUL:  num_q <= cspu_pkg::NUM_W'(prod);
				cspu_pkg::OP_ADDH: num_q <= num_q + cspu_pkg::NUM_W'(half_q);
				cspu_pkg::OP_DINIT: begin
					// quotient is at most 1000, so the top part is already below the sum
					rem_q <= num_q[cspu_pkg::NUM_W-1:cspu_pkg::SHARE_W];
					shf_q <= num_q[cspu_pkg::SHARE_W-1:0];
					quo_q <= '0;
				end
				cspu_pkg::OP_DSTEP: begin
					rem_q <= ge ? trial[cspu_pkg::TOTAL_W-1:0]
						: {rem_q[cspu_pkg::TOTAL_W-2:0], shf_q[cspu_pkg::SHARE_W-1]};
					shf_q <= {shf_q[cspu_pkg::SHARE_W-2:0], 1'b0};
					quo_q <= {quo_q[cspu_pkg::SHARE_W-2:0], ge};
				end
				cspu_pkg::OP_STORE: begin
					share_q[lane_q] <= quo_q;
					psum_q          <= psum_q + quo_q;
				end
				cspu_pkg::OP_OUT: out_data_q <= {{cspu_pkg::OUT_PAD_W{1'b0}}, acc_q, psum_q,
					share_q[3], share_q[2], share_q[1], share_q[0]};
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/core/cpu_state_permille_unit.sv =====
// Top level of the CPU state per-mille unit.
//
// Each input transaction carries one sample of four cumulative tick counters
// (user, nice, system, idle). The unit keeps the previous sample (zero after
// reset), takes each counter's advance modulo 2^32 so that wraps come out
// right, sums the four advances (a zero sum is reported as one) and returns
// one output transaction with each share as a per-mille value rounded half
// up, the sum of the four shares and the tick total. A short microprogram
// drives the datapath; one shared restoring divider yields one quotient bit a
// cycle. An item passes from acceptance to the registered result through
// a load, 3 adds and a fix-up, then per state a multiply, a rounding add,
// a divider set-up, 10 divide steps and a store, then an output step. A
// new sample is accepted as soon as the sequencer is back at its idle step,
// even while the previous result still waits in the output register.
module cpu_state_permille_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// user_ticks[31:0], nice_ticks[63:32], system_ticks[95:64], idle_ticks[127:96]
	input  logic [cspu_pkg::IN_W-1:0]   s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// user_permille[9:0], nice_permille[19:10], system_permille[29:20],
	// idle_permille[39:30], permille_sum[49:40], elapsed_ticks[83:50], zero[87:84]
	output logic [cspu_pkg::OUT_W-1:0]  m_axis_tdata
);

	cspu_pkg::ctrl_t ctrl;
	cspu_pkg::stat_t stat;

	// sequencer: step counter and microcode ROM
	cspu_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.stat     (stat),
		.ctrl     (ctrl),
		.in_ready (s_axis_tready)
	);

	// datapath: differences, total, divider and result register
	cspu_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.in_data   (s_axis_tdata),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata)
	);

	// the sequencer leaves idle straight after taking a sample
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken again while a sample is in work");

	// the reported total is never zero
	a_total_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[83:50] != '0)
		else $error("elapsed tick total of zero");

	// each share stays within 0..1000
	a_share_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[9:0] <= 10'd1000) && (m_axis_tdata[19:10] <= 10'd1000)
			&& (m_axis_tdata[29:20] <= 10'd1000) && (m_axis_tdata[39:30] <= 10'd1000))
		else $error("share above one thousand");

	// the sum field matches the four shares
	a_sum_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[49:40] == 10'(m_axis_tdata[9:0] + m_axis_tdata[19:10]
			+ m_axis_tdata[29:20] + m_axis_tdata[39:30]))
		else $error("share sum mismatch");

endmodule
